### sv/lifl_pkg.sv
`default_nettype none
package lifl_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_MEMBRANE_RATE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INHIBITION_RATE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_RATE    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INHIBIT_WEIGHT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPIKE_GAIN      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_NEURONS  = 3'd5;

   localparam logic [2:0] MODE_WEIGHT    = 3'd0;
   localparam logic [2:0] MODE_THRESHOLD = 3'd1;
   localparam logic [2:0] MODE_TRIAL     = 3'd2;
   localparam logic [2:0] MODE_RATE      = 3'd3;
   localparam logic [2:0] MODE_TICK      = 3'd4;
   localparam logic [2:0] MODE_READ      = 3'd5;

   localparam logic [11:0] COUNT_MAX = 12'hFFF;

   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

   typedef struct packed {
      logic [2:0]         mode;
      logic [10:0]        neuron_index;
      logic [5:0]         source_index;
      logic [3:0]         weight_value;
      logic signed [31:0] sample_value;
   } req_word_type;

   typedef struct packed {
      logic [11:0]        spike_count;
      logic signed [31:0] inhibition_level;
      logic               responded;
   } rsp_word_type;

   typedef struct packed {
      logic rd_en;
      logic acc_clear;
      logic weight_we;
      logic rate_we;
   } syn_ctl_type;

   typedef struct packed {
      logic rd_en;
      logic mul_en;
      logic upd_en;
      logic clr_en;
      logic thr_we;
   } nrn_ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      logic signed [31:0] r;
      if (x > SAT_HI) begin
         r = 32'sh7FFFFFFF;
      end else if (x < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### sv/spiking_neuron_layer_with_feedback.sv
`default_nettype none
// Layer of leaky integrate-and-fire neurons with one shared inhibitory unit, signed Q16.16
// with saturation. One item is taken at a time and gives one result word. Weight, threshold,
// rate, read and unused modes go from accept straight to the done state. Trial start sweeps the
// membrane/flag memory one neuron per cycle. A tick runs over n = min(active_neurons,
// NUM_NEURONS) neurons, reading their weights through the weight memory port, which delivers
// one weight per cycle to the multiply-accumulate. After reset the same clearing pass runs
// over every neuron before the first item is taken; configuration writes are taken at any time.
module spiking_neuron_layer_with_feedback
   import lifl_pkg::*;
#(
   parameter int NUM_NEURONS = 2048,
   parameter int NUM_SOURCES = 64,
   parameter int WEIGHT_BITS = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_word_type           req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_word_type                rsp_word,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int NB    = $clog2(NUM_NEURONS);
   localparam int SB    = $clog2(NUM_SOURCES);
   localparam int CNT_W = $clog2(NUM_NEURONS + 1);
   localparam int ACC_W = 33 + WEIGHT_BITS + SB;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_CLEAR  = 4'd1;
   localparam logic [3:0] ST_TPRE   = 4'd2;
   localparam logic [3:0] ST_TPRE2  = 4'd3;
   localparam logic [3:0] ST_NSTART = 4'd4;
   localparam logic [3:0] ST_ACC    = 4'd5;
   localparam logic [3:0] ST_WAIT   = 4'd6;
   localparam logic [3:0] ST_MUL    = 4'd7;
   localparam logic [3:0] ST_UPD    = 4'd8;
   localparam logic [3:0] ST_FIN1   = 4'd9;
   localparam logic [3:0] ST_FIN2   = 4'd10;
   localparam logic [3:0] ST_DONE   = 4'd11;

   logic [15:0] membrane_rate_ff;
   logic [15:0] inhibition_rate_ff;
   logic [15:0] current_rate_ff;
   logic [30:0] inhibit_weight_ff;
   logic [30:0] spike_gain_ff;
   logic [11:0] active_neurons_ff;

   logic [3:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SB-1:0]      src_ff, src_in;
   logic               pend_ff, pend_in;
   logic [2:0]         mode_ff;
   logic               n_ok_ff;
   logic [11:0]        count_ff, count_in;
   logic signed [31:0] inh_val_ff, inh_val_in;
   logic signed [31:0] cur_ff, cur_in;
   logic [11:0]        prev_ff, prev_in;
   logic signed [63:0] ip_ff;
   logic [42:0]        fbp_ff;
   logic signed [31:0] inhib_ff;
   logic signed [31:0] fb_ff;
   logic signed [50:0] lp_i_ff;
   logic signed [50:0] lp_c_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff;

   logic               accept;
   logic               n_ok;
   logic               s_ok;
   logic [CNT_W-1:0]   n_act;
   logic               out_free;
   syn_ctl_type        syn_ctl;
   nrn_ctl_type        nrn_ctl;
   logic [NB-1:0]      n_addr;
   logic [SB-1:0]      s_addr;
   logic signed [ACC_W-1:0] acc;
   logic signed [31:0] drive;
   logic               spike;
   logic               flag;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign n_ok      = 32'(req_word.neuron_index) < 32'(NUM_NEURONS);
   assign s_ok      = 32'(req_word.source_index) < 32'(NUM_SOURCES);
   assign n_act     = (32'(active_neurons_ff) > 32'(NUM_NEURONS)) ?
                      CNT_W'(NUM_NEURONS) : CNT_W'(active_neurons_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign n_addr    = (state_ff == ST_IDLE) ? NB'(req_word.neuron_index) : cnt_ff[NB-1:0];
   assign s_addr    = (state_ff == ST_IDLE) ? SB'(req_word.source_index) : src_ff;
   assign drive     = sat32(66'(acc));

   always_ff @(posedge clock) begin
      if (reset) begin
         membrane_rate_ff   <= 16'd3277;
         inhibition_rate_ff <= 16'd655;
         current_rate_ff    <= 16'd3277;
         inhibit_weight_ff  <= 31'd393216;
         spike_gain_ff      <= 31'd1966080;
         active_neurons_ff  <= 12'd2000;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MEMBRANE_RATE:   membrane_rate_ff   <= csr_wdata[15:0];
            CSR_INHIBITION_RATE: inhibition_rate_ff <= csr_wdata[15:0];
            CSR_CURRENT_RATE:    current_rate_ff    <= csr_wdata[15:0];
            CSR_INHIBIT_WEIGHT:  inhibit_weight_ff  <= csr_wdata;
            CSR_SPIKE_GAIN:      spike_gain_ff      <= csr_wdata;
            CSR_ACTIVE_NEURONS:  active_neurons_ff  <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      src_in     = src_ff;
      pend_in    = pend_ff;
      count_in   = count_ff;
      inh_val_in = inh_val_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      syn_ctl    = '0;
      nrn_ctl    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DONE;
               case (req_word.mode)
                  MODE_WEIGHT:    syn_ctl.weight_we = n_ok && s_ok;
                  MODE_THRESHOLD: nrn_ctl.thr_we = n_ok;
                  MODE_RATE:      syn_ctl.rate_we = s_ok;
                  MODE_READ:      nrn_ctl.rd_en = 1'b1;
                  MODE_TRIAL: begin
                     state_in   = ST_CLEAR;
                     pend_in    = 1'b1;
                     cnt_in     = '0;
                     inh_val_in = '0;
                     cur_in     = '0;
                     prev_in    = '0;
                  end
                  MODE_TICK: begin
                     state_in = ST_TPRE;
                     count_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            nrn_ctl.clr_en = 1'b1;
            cnt_in = CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == CNT_W'(NUM_NEURONS - 1)) begin
               cnt_in   = '0;
               state_in = pend_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_TPRE: state_in = ST_TPRE2;
         ST_TPRE2: begin
            cnt_in   = '0;
            state_in = (n_act == '0) ? ST_FIN1 : ST_NSTART;
         end
         ST_NSTART: begin
            nrn_ctl.rd_en     = 1'b1;
            syn_ctl.acc_clear = 1'b1;
            state_in          = ST_ACC;
         end
         ST_ACC: begin
            syn_ctl.rd_en = 1'b1;
            src_in = SB'(src_ff + 1'b1);
            if (src_ff == SB'(NUM_SOURCES - 1)) begin
               src_in   = '0;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: state_in = ST_MUL;
         ST_MUL: begin
            nrn_ctl.mul_en = 1'b1;
            state_in       = ST_UPD;
         end
         ST_UPD: begin
            nrn_ctl.upd_en = 1'b1;
            if (spike && count_ff != COUNT_MAX) begin
               count_in = count_ff + 12'd1;
            end
            if (CNT_W'(cnt_ff + 1'b1) == n_act) begin
               state_in = ST_FIN1;
            end else begin
               cnt_in   = CNT_W'(cnt_ff + 1'b1);
               state_in = ST_NSTART;
            end
         end
         ST_FIN1: state_in = ST_FIN2;
         ST_FIN2: begin
            inh_val_in = sat32(66'(inh_val_ff) + 66'(lp_i_ff >>> 16));
            cur_in     = sat32(66'(cur_ff) + 66'(lp_c_ff >>> 16));
            prev_in    = count_ff;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cnt_ff     <= '0;
         src_ff     <= '0;
         pend_ff    <= 1'b0;
         count_ff   <= '0;
         inh_val_ff <= '0;
         cur_ff     <= '0;
         prev_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         src_ff     <= src_in;
         pend_ff    <= pend_in;
         count_ff   <= count_in;
         inh_val_ff <= inh_val_in;
         cur_ff     <= cur_in;
         prev_ff    <= prev_in;
      end
   end

   // global inhibition and feedback current arithmetic
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_word.mode;
         n_ok_ff <= n_ok;
      end
      if (state_ff == ST_TPRE) begin
         ip_ff  <= 64'($signed({1'b0, inhibit_weight_ff})) * 64'(inh_val_ff);
         fbp_ff <= 43'(spike_gain_ff) * 43'(prev_ff);
      end
      if (state_ff == ST_TPRE2) begin
         inhib_ff <= sat32(66'(ip_ff >>> 16));
         fb_ff    <= sat32(66'($signed({1'b0, fbp_ff})));
      end
      if (state_ff == ST_FIN1) begin
         lp_i_ff <= 51'(34'(cur_ff) - 34'(inh_val_ff)) *
                    51'($signed({1'b0, inhibition_rate_ff}));
         lp_c_ff <= 51'(34'(fb_ff) - 34'(cur_ff)) *
                    51'($signed({1'b0, current_rate_ff}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_word_ff.spike_count      <= (mode_ff == MODE_TICK) ? count_ff : 12'd0;
         rsp_word_ff.inhibition_level <= inh_val_ff;
         rsp_word_ff.responded        <= (mode_ff == MODE_READ) && n_ok_ff && flag;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   lifl_syn #(
      .NUM_NEURONS (NUM_NEURONS),
      .NUM_SOURCES (NUM_SOURCES),
      .WEIGHT_BITS (WEIGHT_BITS),
      .NB          (NB),
      .SB          (SB),
      .ACC_W       (ACC_W)
   ) u_syn (
      .clock       (clock),
      .ctl         (syn_ctl),
      .n_addr      (n_addr),
      .s_addr      (s_addr),
      .weight_data (WEIGHT_BITS'(req_word.weight_value)),
      .rate_data   (req_word.sample_value),
      .acc         (acc)
   );

   lifl_nrn #(
      .NUM_NEURONS (NUM_NEURONS),
      .NB          (NB)
   ) u_nrn (
      .clock    (clock),
      .ctl      (nrn_ctl),
      .addr     (n_addr),
      .thr_data (req_word.sample_value),
      .drive    (drive),
      .inhib    (inhib_ff),
      .rate     (membrane_rate_ff),
      .spike    (spike),
      .flag     (flag)
   );

`ifndef SYNTH
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> req_stall)
      else $error("item taken during clearing pass");
   a_fin_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN2 |=> state_ff == ST_DONE)
      else $error("tick did not finish into result");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result loaded outside done state");
   a_src_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_ACC |-> src_ff == '0)
      else $error("source counter left nonzero");
`endif

endmodule
`default_nettype wire

### sv/lifl_syn.sv
`default_nettype none
module lifl_syn
   import lifl_pkg::*;
#(
   parameter int NUM_NEURONS = 2048,
   parameter int NUM_SOURCES = 64,
   parameter int WEIGHT_BITS = 4,
   parameter int NB          = $clog2(NUM_NEURONS),
   parameter int SB          = $clog2(NUM_SOURCES),
   parameter int ACC_W       = 33 + WEIGHT_BITS + SB
) (
   input  wire logic                    clock,
   input  wire syn_ctl_type             ctl,
   input  wire logic [NB-1:0]           n_addr,
   input  wire logic [SB-1:0]           s_addr,
   input  wire logic [WEIGHT_BITS-1:0]  weight_data,
   input  wire logic signed [31:0]      rate_data,
   output logic signed [ACC_W-1:0]      acc
);

   localparam int WA     = $clog2(NUM_NEURONS * NUM_SOURCES);
   localparam int PROD_W = 33 + WEIGHT_BITS;

   logic [WEIGHT_BITS-1:0] weight_mem [NUM_NEURONS * NUM_SOURCES];
   logic signed [31:0]     rate_mem [NUM_SOURCES];

   logic [WA-1:0]              w_addr;
   logic [WEIGHT_BITS-1:0]     weight_q_ff;
   logic signed [31:0]         rate_q_ff;
   logic                       add_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [PROD_W-1:0]   prod;

   assign w_addr = WA'(WA'(n_addr) * WA'(NUM_SOURCES) + WA'(s_addr));

   always_ff @(posedge clock) begin
      if (ctl.weight_we) begin
         weight_mem[w_addr] <= weight_data;
      end
      if (ctl.rd_en) begin
         weight_q_ff <= weight_mem[w_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rate_we) begin
         rate_mem[s_addr] <= rate_data;
      end
      if (ctl.rd_en) begin
         rate_q_ff <= rate_mem[s_addr];
      end
   end

   assign prod = PROD_W'(rate_q_ff) * PROD_W'($signed({1'b0, weight_q_ff}));

   always_ff @(posedge clock) begin
      add_ff <= ctl.rd_en;
      if (ctl.acc_clear) begin
         acc_ff <= '0;
      end else if (add_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod);
      end
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

### sv/lifl_nrn.sv
`default_nettype none
module lifl_nrn
   import lifl_pkg::*;
#(
   parameter int NUM_NEURONS = 2048,
   parameter int NB          = $clog2(NUM_NEURONS)
) (
   input  wire logic               clock,
   input  wire nrn_ctl_type        ctl,
   input  wire logic [NB-1:0]      addr,
   input  wire logic signed [31:0] thr_data,
   input  wire logic signed [31:0] drive,
   input  wire logic signed [31:0] inhib,
   input  wire logic [15:0]        rate,
   output logic                    spike,
   output logic                    flag
);

   logic [32:0]        ns_mem [NUM_NEURONS];
   logic signed [31:0] thr_mem [NUM_NEURONS];

   logic [32:0]        ns_q_ff;
   logic signed [31:0] thr_q_ff;
   logic signed [31:0] v_q;
   logic signed [33:0] diff;
   logic signed [50:0] prod_in;
   logic signed [50:0] prod_ff;
   logic signed [31:0] v_new;
   logic [32:0]        ns_wdata;

   assign v_q     = ns_q_ff[31:0];
   assign diff    = 34'(drive) - 34'(inhib) - 34'(v_q);
   assign prod_in = 51'(diff) * 51'($signed({1'b0, rate}));
   assign v_new   = sat32(66'(v_q) + 66'(prod_ff >>> 16));
   assign spike   = ctl.upd_en && (v_new > thr_q_ff);
   assign flag    = ns_q_ff[32];

   always_comb begin
      if (ctl.clr_en) begin
         ns_wdata = '0;
      end else if (spike) begin
         ns_wdata = {1'b1, 32'd0};
      end else begin
         ns_wdata = {ns_q_ff[32], v_new};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clr_en || ctl.upd_en) begin
         ns_mem[addr] <= ns_wdata;
      end
      if (ctl.rd_en) begin
         ns_q_ff <= ns_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.thr_we) begin
         thr_mem[addr] <= thr_data;
      end
      if (ctl.rd_en) begin
         thr_q_ff <= thr_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

endmodule
`default_nettype wire
